[design/rle565_pkg.sv]
package rle565_pkg;

	localparam logic [7:0] TypeCompressed = 8'h01;
	localparam int unsigned RepeatBit = 5;

	localparam int unsigned ColorW = 16;
	localparam int unsigned RunW = 9;
	localparam int unsigned CountW = 32;

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_WIDTH_HI,
		PH_WIDTH_LO,
		PH_HEIGHT_HI,
		PH_HEIGHT_LO,
		PH_COLOR_HI,
		PH_COLOR_LO,
		PH_COUNT
	} phase_t;

	typedef struct packed {
		logic [ColorW-1:0] color;
		logic [RunW-1:0] run_length;
		logic last;
	} run_t;

endpackage

[design/rle565_in_stage.sv]
module rle565_in_stage import rle565_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [7:0] in_byte,
	output logic in_stall,
	input logic advance_ok,
	output logic fire,
	output logic [7:0] byte_s1
);

	logic valid_s1;
	logic accept;

	assign fire = valid_s1 && advance_ok;
	assign in_stall = valid_s1 && !advance_ok;
	assign accept = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			byte_s1 <= in_byte;
		end
	end

endmodule

[design/rle565_decode.sv]
module rle565_decode import rle565_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic fire,
	input logic [7:0] byte_s1,
	output logic res_valid,
	output run_t res
);

	phase_t phase_q, phase_d;
	logic comp_q, comp_d;
	logic [15:0] width_q, width_d;
	logic [7:0] height_high_q, height_high_d;
	logic [CountW-1:0] pixels_left_q, pixels_left_d;
	logic [7:0] color_high_q, color_high_d;
	logic [7:0] color_low_q, color_low_d;

	logic [15:0] height;
	logic [RunW-1:0] len;
	logic [RunW-1:0] n;
	logic [CountW-1:0] rem;
	logic emit;

	assign height = {height_high_q, byte_s1};

	always_comb begin
		len = (phase_q == PH_COUNT) ? ({1'b0, byte_s1} + RunW'(1)) : RunW'(1);
		n = ({{(CountW-RunW){1'b0}}, len} > pixels_left_q) ? pixels_left_q[RunW-1:0] : len;
		rem = pixels_left_q - {{(CountW-RunW){1'b0}}, n};
	end

	always_comb begin
		phase_d = phase_q;
		comp_d = comp_q;
		width_d = width_q;
		height_high_d = height_high_q;
		pixels_left_d = pixels_left_q;
		color_high_d = color_high_q;
		color_low_d = color_low_q;
		emit = 1'b0;
		unique case (phase_q)
			PH_TYPE: begin
				comp_d = (byte_s1 == TypeCompressed);
				phase_d = PH_WIDTH_HI;
			end
			PH_WIDTH_HI: begin
				width_d = {byte_s1, 8'h00};
				phase_d = PH_WIDTH_LO;
			end
			PH_WIDTH_LO: begin
				width_d = {width_q[15:8], byte_s1};
				phase_d = PH_HEIGHT_HI;
			end
			PH_HEIGHT_HI: begin
				height_high_d = byte_s1;
				phase_d = PH_HEIGHT_LO;
			end
			PH_HEIGHT_LO: begin
				pixels_left_d = width_q * height;
				phase_d = (width_q == 16'd0 || height == 16'd0) ? PH_TYPE : PH_COLOR_HI;
			end
			PH_COLOR_HI: begin
				color_high_d = byte_s1;
				phase_d = PH_COLOR_LO;
			end
			PH_COLOR_LO: begin
				color_low_d = byte_s1;
				if (comp_q) begin
					color_low_d[RepeatBit] = 1'b1;
				end
				if (comp_q && byte_s1[RepeatBit]) begin
					phase_d = PH_COUNT;
				end else begin
					emit = 1'b1;
				end
			end
			PH_COUNT: begin
				emit = 1'b1;
			end
			default: begin
				phase_d = PH_TYPE;
			end
		endcase
		if (emit) begin
			pixels_left_d = rem;
			phase_d = (rem == '0) ? PH_TYPE : PH_COLOR_HI;
		end
	end

	assign res_valid = fire && emit;
	assign res.color = {color_high_q, color_low_d};
	assign res.run_length = n;
	assign res.last = (rem == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_TYPE;
			comp_q <= 1'b0;
			pixels_left_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			comp_q <= comp_d;
			pixels_left_q <= pixels_left_d;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			width_q <= width_d;
			height_high_q <= height_high_d;
			color_high_q <= color_high_d;
			color_low_q <= color_low_d;
		end
	end

endmodule

[design/rle565_out_stage.sv]
module rle565_out_stage import rle565_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic load,
	input run_t res,
	output logic advance_ok,
	output logic out_valid,
	input logic out_stall,
	output run_t out_res
);

	logic valid_q;
	run_t res_q;

	assign advance_ok = !valid_q || !out_stall;
	assign out_valid = valid_q;
	assign out_res = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance_ok) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_ok && load) begin
			res_q <= res;
		end
	end

endmodule

[design/rle_rgb565_image_decoder_core.sv]
// Decodes an RGB565 image byte stream (5-byte header, then pixel pairs, optional run
// counts in type 1 streams) into colored runs. Takes one byte per cycle with no gaps
// unless the output stalls; the run that a beat completes passes the input register
// and then the result register. Header and color-high beats give no run.
module rle_rgb565_image_decoder_core import rle565_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic data_valid,
	output logic data_stall,
	input logic [7:0] data_byte,
	output logic pixel_valid,
	input logic pixel_stall,
	output logic [ColorW-1:0] pixel_color,
	output logic [RunW-1:0] run_length,
	output logic last_run
);

	logic advance_ok;
	logic fire;
	logic [7:0] byte_s1;
	logic res_valid;
	run_t res;
	run_t out_res;

	rle565_in_stage u_in (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(data_valid),
		.in_byte(data_byte),
		.in_stall(data_stall),
		.advance_ok(advance_ok),
		.fire(fire),
		.byte_s1(byte_s1)
	);

	rle565_decode u_dec (
		.clk(clk),
		.arst_n(arst_n),
		.fire(fire),
		.byte_s1(byte_s1),
		.res_valid(res_valid),
		.res(res)
	);

	rle565_out_stage u_out (
		.clk(clk),
		.arst_n(arst_n),
		.load(res_valid),
		.res(res),
		.advance_ok(advance_ok),
		.out_valid(pixel_valid),
		.out_stall(pixel_stall),
		.out_res(out_res)
	);

	assign pixel_color = out_res.color;
	assign run_length = out_res.run_length;
	assign last_run = out_res.last;

	a_run_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> run_length != '0)
		else $error("zero-length run");

	a_run_max: assert property (@(posedge clk) disable iff (!arst_n)
		pixel_valid |-> run_length <= RunW'(256))
		else $error("run too long");

	a_stall_only_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		data_stall |-> pixel_valid && pixel_stall)
		else $error("input stalled without output backpressure");

endmodule

[verif/rle565_run_checker.sv]
module rle565_run_checker import rle565_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic data_valid,
	input logic data_stall,
	input logic [7:0] data_byte,
	input logic pixel_valid,
	input logic pixel_stall,
	input logic [ColorW-1:0] pixel_color,
	input logic [RunW-1:0] run_length,
	input logic last_run,
	output int unsigned mismatches,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [7:0] RepeatMask = 8'h01 << RepeatBit;

	phase_t ph;
	logic packed_mode;
	logic [15:0] img_width;
	logic [7:0] img_height_hi;
	logic [CountW-1:0] pixels_owed;
	logic [7:0] hue_hi;
	logic [7:0] hue_lo;
	run_t runs_due[$];
	run_t want;

	task automatic note_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] exp_val);
		$display("%0t ns: %s mismatch, got %0h, expected %0h", $time, what, got, exp_val);
		mismatches++;
	endtask

	function automatic void close_run(input logic [RunW-1:0] len);
		logic [RunW-1:0] n;
		run_t r;
		n = (CountW'(len) > pixels_owed) ? pixels_owed[RunW-1:0] : len;
		pixels_owed -= CountW'(n);
		r.color = {hue_hi, hue_lo};
		r.run_length = n;
		r.last = (pixels_owed == 0);
		runs_due.push_back(r);
		ph = (pixels_owed == 0) ? PH_TYPE : PH_COLOR_HI;
	endfunction

	function automatic void decode_byte(input logic [7:0] b);
		case (ph)
			PH_TYPE: begin
				packed_mode = (b == TypeCompressed);
				ph = PH_WIDTH_HI;
			end
			PH_WIDTH_HI: begin
				img_width = {b, 8'h00};
				ph = PH_WIDTH_LO;
			end
			PH_WIDTH_LO: begin
				img_width[7:0] = b;
				ph = PH_HEIGHT_HI;
			end
			PH_HEIGHT_HI: begin
				img_height_hi = b;
				ph = PH_HEIGHT_LO;
			end
			PH_HEIGHT_LO: begin
				pixels_owed = CountW'(img_width) * CountW'({img_height_hi, b});
				ph = (pixels_owed == 0) ? PH_TYPE : PH_COLOR_HI;
			end
			PH_COLOR_HI: begin
				hue_hi = b;
				ph = PH_COLOR_LO;
			end
			PH_COLOR_LO: begin
				if (packed_mode) begin
					hue_lo = b | RepeatMask;
					if (b[RepeatBit])
						ph = PH_COUNT;
					else
						close_run(RunW'(1));
				end else begin
					hue_lo = b;
					close_run(RunW'(1));
				end
			end
			default: begin
				close_run(RunW'(b) + RunW'(1));
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph = PH_TYPE;
			packed_mode = 1'b0;
			img_width = '0;
			img_height_hi = '0;
			pixels_owed = '0;
			hue_hi = '0;
			hue_lo = '0;
			runs_due.delete();
			mismatches = 0;
			outstanding = 0;
		end else begin
			if (pixel_valid && !pixel_stall) begin
				if (runs_due.size() == 0) begin
					note_mismatch("unexpected run, color", 32'(pixel_color), 0);
				end else begin
					want = runs_due.pop_front();
					if (pixel_color !== want.color)
						note_mismatch("pixel_color", 32'(pixel_color), 32'(want.color));
					if (run_length !== want.run_length)
						note_mismatch("run_length", 32'(run_length), 32'(want.run_length));
					if (last_run !== want.last)
						note_mismatch("last_run", 32'(last_run), 32'(want.last));
				end
			end
			if (data_valid && !data_stall)
				decode_byte(data_byte);
			outstanding = runs_due.size();
		end
	end

endmodule

[verif/rle_rgb565_image_decoder_core_test.sv]
module rle_rgb565_image_decoder_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rle565_pkg::*;

	localparam logic [7:0] RepeatMask = 8'h01 << RepeatBit;
	localparam logic [7:0] PlainType = 8'h00;

	logic clk = 1'b0;
	logic arst_n;
	logic data_valid;
	logic data_stall;
	logic [7:0] data_byte;
	logic pixel_valid;
	logic pixel_stall;
	logic [ColorW-1:0] pixel_color;
	logic [RunW-1:0] run_length;
	logic last_run;
	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned sent = 0;
	bit calm = 1'b0;
	bit gappy = 1'b0;

	always #5 clk = ~clk;

	rle_rgb565_image_decoder_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_color(pixel_color),
		.run_length(run_length),
		.last_run(last_run)
	);

	rle565_run_checker i_checker (
		.clk(clk),
		.arst_n(arst_n),
		.data_valid(data_valid),
		.data_stall(data_stall),
		.data_byte(data_byte),
		.pixel_valid(pixel_valid),
		.pixel_stall(pixel_stall),
		.pixel_color(pixel_color),
		.run_length(run_length),
		.last_run(last_run),
		.mismatches(mismatches),
		.outstanding(outstanding)
	);

	// one beat on the byte channel; returns at the accepting edge
	task automatic send_byte(input logic [7:0] b);
		if (!calm && gappy && $urandom_range(0, 3) == 0) begin
			data_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		data_valid <= 1'b1;
		data_byte <= b;
		do @(negedge clk); while (data_stall);
		@(posedge clk);
		sent++;
	endtask

	task automatic send_picture(input logic [7:0] kind, input logic [15:0] w,
			input logic [15:0] h, input int unsigned top_count);
		int unsigned owed;
		int unsigned span;
		logic [7:0] hi;
		logic [7:0] lo;
		logic [7:0] cnt;
		owed = 32'(w) * 32'(h);
		send_byte(kind);
		send_byte(w[15:8]);
		send_byte(w[7:0]);
		send_byte(h[15:8]);
		send_byte(h[7:0]);
		while (owed > 0) begin
			hi = 8'($urandom_range(0, 255));
			lo = 8'($urandom_range(0, 255));
			send_byte(hi);
			send_byte(lo);
			if (kind == TypeCompressed && lo[RepeatBit]) begin
				cnt = 8'($urandom_range(0, top_count));
				send_byte(cnt);
				span = 32'(cnt) + 1;
				owed -= (span > owed) ? owed : span;
			end else begin
				owed--;
			end
		end
	endtask

	initial begin
		int unsigned sel;
		int unsigned pick;
		logic [7:0] kind;
		arst_n <= 1'b0;
		data_valid <= 1'b0;
		data_byte <= 8'h00;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero-size image
		send_byte(TypeCompressed);
		send_byte(8'hFF);
		send_byte(8'hFF);
		send_byte(8'h00);
		send_byte(8'h00);
		// 1x3 compressed: flag clear, then a run clipped at the image end
		send_byte(TypeCompressed);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h03);
		send_byte(8'hFF);
		send_byte(8'hDF);
		send_byte(8'h12);
		send_byte(RepeatMask);
		send_byte(8'hFF);
		// 256x1 filled by one full-length run
		send_byte(TypeCompressed);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(8'h00);
		send_byte(8'h01);
		send_byte(8'h00);
		send_byte(RepeatMask);
		send_byte(8'hFF);

		while (sent < 1900) begin
			gappy = $urandom_range(0, 1);
			calm = (sent > 1600);
			pick = $urandom_range(0, 7);
			if (pick < 4)
				kind = TypeCompressed;
			else if (pick < 6)
				kind = PlainType;
			else
				kind = 8'($urandom_range(0, 255));
			sel = $urandom_range(0, 31);
			if (sel == 0)
				send_picture(kind, 16'($urandom_range(0, 65535)), 16'h0000, 7);
			else if (sel == 1)
				send_picture(kind, 16'h0000, 16'($urandom_range(0, 65535)), 7);
			else if (sel == 2)
				send_picture(TypeCompressed, 16'($urandom_range(1, 64)),
						16'($urandom_range(1, 8)), 255);
				else
				send_picture(kind, 16'($urandom_range(1, 4)), 16'($urandom_range(1, 4)),
						$urandom_range(0, 1) ? 7 : 255);
		end
		// loose bytes at the tail
		repeat (20) send_byte(8'($urandom_range(0, 255)));
		data_valid <= 1'b0;

		do @(negedge clk); while (outstanding != 0);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		int unsigned rounds;
		rounds = 0;
		pixel_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			rounds++;
			if (rounds == 30) begin
				// long hold so the pipeline backs up into the byte channel
				pixel_stall <= 1'b1;
				repeat (400) @(posedge clk);
				pixel_stall <= 1'b0;
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				pixel_stall <= 1'b1;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				pixel_stall <= 1'b0;
			end
			repeat ($urandom_range(1, 30)) @(posedge clk);
		end
	end

	initial begin
		#5_000_000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule
